// ----- rtl/cse_pkg.sv -----
// Shared constants, job descriptor type and escape functions for the byte escaper.
`timescale 1ns / 1ps
package cse_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int CAP_WIDTH   = 16;
   localparam int CMP_WIDTH   = ((COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH) + 1;
   localparam int ROOM_NEEDED = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(255);

   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_BEL       = 8'h07;
   localparam logic [7:0] CH_BS        = 8'h08;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_VT        = 8'h0B;
   localparam logic [7:0] CH_FF        = 8'h0C;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_ESC       = 8'h1B;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_DEL       = 8'h7F;
   localparam logic [7:0] CH_LOWER_X   = 8'h78;

   typedef logic [2:0] esc_len_type;

   typedef struct packed {
      logic [3:0][7:0] esc_bytes;
      esc_len_type     esc_len;
      logic            has_term;
      logic            term_trunc;
   } job_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] d;
      if (v < 4'd10) begin
         d = 8'h30 + {4'h0, v};
      end else begin
         d = 8'h57 + {4'h0, v};
      end
      return d;
   endfunction

   function automatic job_type escape_byte(input logic [7:0] c);
      job_type    j;
      logic [7:0] letter;
      j      = '0;
      letter = CH_NUL;
      case (c)
         CH_NUL:                            letter = 8'h30;
         CH_BEL:                            letter = 8'h61;
         CH_BS:                             letter = 8'h62;
         CH_TAB:                            letter = 8'h74;
         CH_LF:                             letter = 8'h6E;
         CH_VT:                             letter = 8'h76;
         CH_FF:                             letter = 8'h66;
         CH_CR:                             letter = 8'h72;
         CH_ESC:                            letter = 8'h65;
         CH_QUOTE, CH_COMMA, CH_BACKSLASH:  letter = c;
         default:                           letter = CH_NUL;
      endcase
      if (c > CH_DEL) begin
         j.esc_bytes[0] = c;
         j.esc_len      = 3'd1;
      end else if (letter != CH_NUL) begin
         j.esc_bytes[0] = CH_BACKSLASH;
         j.esc_bytes[1] = letter;
         j.esc_len      = 3'd2;
      end else if (c < CH_SPACE || c == CH_DEL) begin
         j.esc_bytes[0] = CH_BACKSLASH;
         j.esc_bytes[1] = CH_LOWER_X;
         j.esc_bytes[2] = hex_digit(c[7:4]);
         j.esc_bytes[3] = hex_digit(c[3:0]);
         j.esc_len      = 3'd4;
      end else begin
         j.esc_bytes[0] = c;
         j.esc_len      = 3'd1;
      end
      return j;
   endfunction

endpackage

// ----- rtl/cse_req_if.sv -----
// Input channel: one source byte per beat with string framing.
`timescale 1ns / 1ps
interface cse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       has_byte;
   logic       string_last;

   modport source (output valid, output in_byte, output has_byte, output string_last,
                   input ready);
   modport sink   (input valid, input in_byte, input has_byte, input string_last,
                   output ready);
endinterface

// ----- rtl/cse_rsp_if.sv -----
// Result channel: one escaped byte per beat.
`timescale 1ns / 1ps
interface cse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_terminator;
   logic       was_truncated;
   logic       run_last;

   modport source (output valid, output out_byte, output is_terminator,
                   output was_truncated, output run_last, input ready);
   modport sink   (input valid, input out_byte, input is_terminator,
                   input was_truncated, input run_last, output ready);
endinterface

// ----- rtl/csv_safe_byte_escaper.sv -----
// Top level of the CSV-safe byte escaper.
// Usage:
//   req_ch carries one source byte per beat (in_byte, has_byte, string_last);
//   rsp_ch carries one escaped byte per beat with terminator, truncation and
//   run_last marks. Both use valid/ready; a beat moves when both are high.
//   csr_wr_en/csr_wr_data write the destination capacity (reset value 255).
// Timing:
//   The first result beat of an item passes through the job queue and then
//   the output register. An item yields 0 to 5 result beats: 1 for a plain byte, 2 for
//   a letter escape, 4 for a hex escape, plus 1 for the terminator on the
//   last byte. The output register sends one beat per cycle while rsp_ch.ready
//   is high, and while it stays high a plain
//   byte stream sustains one item per cycle.
// Reset:
//   Synchronous, active high. Clears the byte count, the cut flag, the job
//   queue and the output register; capacity returns to 255.
// Stall:
//   When rsp_ch.ready is low the current beat holds; the two-entry job queue
//   keeps taking items until full, then req_ch.ready drops.
`timescale 1ns / 1ps
module csv_safe_byte_escaper (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [cse_pkg::CAP_WIDTH-1:0] csr_wr_data,
   cse_req_if.sink                       req_ch,
   cse_rsp_if.source                     rsp_ch
);

   logic             push, pop, full, empty;
   cse_pkg::job_type push_job, head;

   cse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .queue_full  (full),
      .push        (push),
      .push_job    (push_job)
   );

   cse_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .full     (full),
      .empty    (empty)
   );

   cse_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .empty  (empty),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

// ----- rtl/cse_front.sv -----
// Front end: capacity register, room check, string state and job classification.
`timescale 1ns / 1ps
module cse_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [cse_pkg::CAP_WIDTH-1:0] csr_wr_data,
   cse_req_if.sink                       req_ch,
   input  logic                          queue_full,
   output logic                          push,
   output cse_pkg::job_type              push_job
);

   logic [cse_pkg::CAP_WIDTH-1:0]   capacity_ff;
   logic [cse_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic                            trunc_ff, trunc_in;
   logic                            accept;
   logic [cse_pkg::COUNT_WIDTH:0]   sum5, sum4;
   logic                            no_room;
   cse_pkg::job_type                esc;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;

   assign sum5    = {1'b0, count_ff} + (cse_pkg::COUNT_WIDTH + 1)'(cse_pkg::ROOM_NEEDED);
   assign sum4    = {1'b0, count_ff} + (cse_pkg::COUNT_WIDTH + 1)'(cse_pkg::ROOM_NEEDED - 1);
   assign no_room = (cse_pkg::CMP_WIDTH'(capacity_ff) < cse_pkg::CMP_WIDTH'(sum5))
                    || sum4[cse_pkg::COUNT_WIDTH];
   assign esc     = cse_pkg::escape_byte(req_ch.in_byte);

   always_comb begin
      push     = 1'b0;
      push_job = esc;
      count_in = count_ff;
      trunc_in = trunc_ff;
      if (accept) begin
         if (trunc_ff) begin
            push = 1'b0;
         end else if (req_ch.has_byte) begin
            push = 1'b1;
            if (no_room) begin
               push_job.esc_len    = '0;
               push_job.has_term   = 1'b1;
               push_job.term_trunc = 1'b1;
               trunc_in            = 1'b1;
            end else begin
               push_job.has_term = req_ch.string_last;
               count_in = count_ff + cse_pkg::COUNT_WIDTH'(esc.esc_len);
            end
         end else if (req_ch.string_last) begin
            push             = 1'b1;
            push_job.esc_len = '0;
            push_job.has_term = 1'b1;
         end
         if (req_ch.string_last) begin
            count_in = '0;
            trunc_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= cse_pkg::CAP_RESET;
         count_ff    <= '0;
         trunc_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         count_ff <= count_in;
         trunc_ff <= trunc_in;
      end
   end

endmodule

// ----- rtl/cse_queue.sv -----
// Short job queue between the front end and the byte sequencer.
`timescale 1ns / 1ps
module cse_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cse_pkg::job_type push_job,
   input  logic             pop,
   output cse_pkg::job_type head,
   output logic             full,
   output logic             empty
);

   cse_pkg::job_type                slot_ff [cse_pkg::QUEUE_DEPTH];
   logic [cse_pkg::QPTR_WIDTH-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [cse_pkg::QCNT_WIDTH-1:0]  fill_ff;
   logic                            do_push, do_pop;

   assign full    = (fill_ff == cse_pkg::QCNT_WIDTH'(cse_pkg::QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

// ----- rtl/cse_back.sv -----
// Back end: walks each queued job and drives one result byte per beat.
`timescale 1ns / 1ps
module cse_back (
   input  logic             clock,
   input  logic             reset,
   input  cse_pkg::job_type head,
   input  logic             empty,
   output logic             pop,
   cse_rsp_if.source        rsp_ch
);

   logic [2:0] idx_ff, idx_in;
   logic       load;
   logic       term_beat, beat_last;
   logic       rsp_valid_ff;
   logic [7:0] byte_ff;
   logic       term_ff, trunc_ff, last_ff;

   assign load      = !empty && (!rsp_valid_ff || rsp_ch.ready);
   assign term_beat = (idx_ff == head.esc_len);
   assign beat_last = term_beat || (!head.has_term && (idx_ff == head.esc_len - 3'd1));
   assign pop       = load && beat_last;

   always_comb begin
      idx_in = idx_ff;
      if (pop) begin
         idx_in = '0;
      end else if (load) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (load) begin
         byte_ff  <= term_beat ? cse_pkg::CH_NUL : head.esc_bytes[idx_ff[1:0]];
         term_ff  <= term_beat;
         trunc_ff <= term_beat && head.term_trunc;
         last_ff  <= beat_last;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.out_byte      = byte_ff;
   assign rsp_ch.is_terminator = term_ff;
   assign rsp_ch.was_truncated = trunc_ff;
   assign rsp_ch.run_last      = last_ff;

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      !empty |-> idx_ff <= head.esc_len)
      else $error("beat index ran past the job");

   a_pop_rewinds: assert property (@(posedge clock) disable iff (reset)
      pop |=> idx_ff == '0)
      else $error("beat index not rewound after job end");

   a_term_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && term_ff |-> last_ff && byte_ff == cse_pkg::CH_NUL)
      else $error("terminator beat is not a closing NUL");

   a_trunc_on_term: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && trunc_ff |-> term_ff)
      else $error("truncation mark off the terminator");

endmodule

// ----- tb/csv_safe_byte_escaper_test.sv -----
// Testbench for the CSV-safe byte escaper: directed and random strings, checked by a predictor.
`timescale 1ns / 1ps
module csv_safe_byte_escaper_test;

   localparam int     CYCLE_LIMIT = 200000;
   localparam longint COUNT_MAX   = (longint'(1) << cse_pkg::COUNT_WIDTH) - 1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       has_byte;
      logic       string_last;
   } str_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_terminator;
      logic       was_truncated;
      logic       run_last;
   } esc_beat_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_wr_en;
   logic [cse_pkg::CAP_WIDTH-1:0] csr_wr_data;

   cse_req_if req_ch ();
   cse_rsp_if rsp_ch ();

   csv_safe_byte_escaper u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   str_item_type                    pending_items[$];
   str_item_type                    cur_item;
   esc_beat_type                    expected_bytes[$];
   logic [cse_pkg::CAP_WIDTH-1:0]   dest_capacity;
   logic [cse_pkg::COUNT_WIDTH-1:0] written_count;
   logic                            cut_seen;
   int                              mismatches;
   int                              cycles;
   int                              burst_left;
   int                              gap_left;
   int                              stall_mode;
   int                              random_items;

   always #2 clock = ~clock;

   task automatic flag_mismatch(input string msg);
      $display("mismatch @%0d: %s", cycles, msg);
      mismatches++;
   endtask

   // Predict the escaped beats caused by one accepted input beat.
   task automatic escape_item(input str_item_type it);
      esc_beat_type beats[$];
      logic [7:0]   esc[4];
      logic [7:0]   letter;
      logic [3:0]   nib;
      int           n_esc;
      longint       used;
      used  = longint'(written_count);
      n_esc = 0;
      if (cut_seen) begin
      end else if (it.has_byte) begin
         if (longint'(dest_capacity) < used + cse_pkg::ROOM_NEEDED
             || used + 4 > COUNT_MAX) begin
            beats.push_back('{cse_pkg::CH_NUL, 1'b1, 1'b1, 1'b0});
            cut_seen = 1'b1;
         end else begin
            letter = cse_pkg::CH_NUL;
            case (it.in_byte)
               cse_pkg::CH_NUL: letter = "0";
               cse_pkg::CH_BEL: letter = "a";
               cse_pkg::CH_BS:  letter = "b";
               cse_pkg::CH_TAB: letter = "t";
               cse_pkg::CH_LF:  letter = "n";
               cse_pkg::CH_VT:  letter = "v";
               cse_pkg::CH_FF:  letter = "f";
               cse_pkg::CH_CR:  letter = "r";
               cse_pkg::CH_ESC: letter = "e";
               cse_pkg::CH_QUOTE, cse_pkg::CH_COMMA, cse_pkg::CH_BACKSLASH: letter = it.in_byte;
               default: letter = cse_pkg::CH_NUL;
            endcase
            if (it.in_byte[7]) begin
               esc[0] = it.in_byte;
               n_esc  = 1;
            end else if (letter != cse_pkg::CH_NUL) begin
               esc[0] = cse_pkg::CH_BACKSLASH;
               esc[1] = letter;
               n_esc  = 2;
            end else if (it.in_byte < cse_pkg::CH_SPACE || it.in_byte == cse_pkg::CH_DEL) begin
               esc[0] = cse_pkg::CH_BACKSLASH;
               esc[1] = cse_pkg::CH_LOWER_X;
               for (int k = 0; k < 2; k++) begin
                  nib        = (k == 0) ? it.in_byte[7:4] : it.in_byte[3:0];
                  esc[2 + k] = (nib < 4'd10) ? {4'h3, nib} : 8'h57 + {4'h0, nib};
               end
               n_esc = 4;
            end else begin
               esc[0] = it.in_byte;
               n_esc  = 1;
            end
            for (int i = 0; i < n_esc; i++) beats.push_back('{esc[i], 1'b0, 1'b0, 1'b0});
            written_count = written_count + cse_pkg::COUNT_WIDTH'(n_esc);
            if (it.string_last) beats.push_back('{cse_pkg::CH_NUL, 1'b1, 1'b0, 1'b0});
         end
      end else if (it.string_last) begin
         beats.push_back('{cse_pkg::CH_NUL, 1'b1, 1'b0, 1'b0});
      end
      if (beats.size() != 0) beats[beats.size() - 1].run_last = 1'b1;
      foreach (beats[i]) expected_bytes.push_back(beats[i]);
      if (it.string_last) begin
         written_count = '0;
         cut_seen      = 1'b0;
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) escape_item(cur_item);
         if (gap_left != 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            cur_item = pending_items.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.in_byte     <= cur_item.in_byte;
            req_ch.has_byte    <= cur_item.has_byte;
            req_ch.string_last <= cur_item.string_last;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: drives rsp_ch.ready from a randomly chosen stall pattern.
   always @(posedge clock) begin
      if (cycles % 50 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ch.ready <= cycles[0];
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_bytes.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat byte %h term %b trunc %b last %b",
               rsp_ch.out_byte, rsp_ch.is_terminator, rsp_ch.was_truncated, rsp_ch.run_last));
         end else begin
            esc_beat_type want;
            want = expected_bytes.pop_front();
            if (rsp_ch.out_byte !== want.out_byte || rsp_ch.is_terminator !== want.is_terminator
                || rsp_ch.was_truncated !== want.was_truncated
                || rsp_ch.run_last !== want.run_last) begin
               flag_mismatch($sformatf("got byte %h term %b trunc %b last %b, want %h %b %b %b",
                  rsp_ch.out_byte, rsp_ch.is_terminator, rsp_ch.was_truncated,
                  rsp_ch.run_last, want.out_byte, want.is_terminator, want.was_truncated,
                  want.run_last));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic add_item(input logic [7:0] b, input logic has, input logic last);
      pending_items.push_back('{b, has, last});
   endtask

   // Hold until every beat is out and the block has gone quiet.
   task automatic settle();
      while (pending_items.size() != 0 || req_ch.valid || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [cse_pkg::CAP_WIDTH-1:0] cap);
      @(posedge clock);
      csr_wr_en     <= 1'b1;
      csr_wr_data   <= cap;
      dest_capacity = cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [7:0] pick_byte();
      logic [7:0] b;
      case ($urandom_range(0, 3))
         0: b = 8'($urandom_range(32, 126));
         1: begin
            case ($urandom_range(0, 11))
               0:  b = cse_pkg::CH_NUL;
               1:  b = cse_pkg::CH_BEL;
               2:  b = cse_pkg::CH_BS;
               3:  b = cse_pkg::CH_TAB;
               4:  b = cse_pkg::CH_LF;
               5:  b = cse_pkg::CH_VT;
               6:  b = cse_pkg::CH_FF;
               7:  b = cse_pkg::CH_CR;
               8:  b = cse_pkg::CH_ESC;
               9:  b = cse_pkg::CH_QUOTE;
               10: b = cse_pkg::CH_COMMA;
               default: b = cse_pkg::CH_BACKSLASH;
            endcase
         end
         2: b = ($urandom_range(0, 4) == 0) ? cse_pkg::CH_DEL : 8'($urandom_range(0, 31));
         default: b = 8'($urandom_range(128, 255));
      endcase
      return b;
   endfunction

   task automatic add_string(input int max_len);
      int len;
      len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, max_len);
      if (len == 0) begin
         add_item(8'($urandom), 1'b0, 1'b1);
         random_items++;
      end
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) add_item(8'($urandom), 1'b0, 1'b0);
         add_item(pick_byte(), 1'b1, i == len - 1);
         random_items++;
      end
   endtask

   initial begin
      logic [cse_pkg::CAP_WIDTH-1:0] caps[6];
      int                            phase_start;
      clock              = 1'b0;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_ch.valid       = 1'b0;
      req_ch.in_byte     = '0;
      req_ch.has_byte    = 1'b0;
      req_ch.string_last = 1'b0;
      rsp_ch.ready       = 1'b0;
      dest_capacity      = cse_pkg::CAP_RESET;
      written_count      = '0;
      cut_seen           = 1'b0;
      mismatches         = 0;
      cycles             = 0;
      stall_mode         = 0;
      random_items       = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      add_item(8'hA5, 1'b0, 1'b0);
      add_item(8'h5A, 1'b0, 1'b1);
      add_item(cse_pkg::CH_NUL, 1'b1, 1'b0);
      add_item(cse_pkg::CH_BEL, 1'b1, 1'b0);
      add_item(cse_pkg::CH_BS, 1'b1, 1'b0);
      add_item(cse_pkg::CH_TAB, 1'b1, 1'b0);
      add_item(cse_pkg::CH_LF, 1'b1, 1'b0);
      add_item(cse_pkg::CH_VT, 1'b1, 1'b0);
      add_item(cse_pkg::CH_FF, 1'b1, 1'b0);
      add_item(cse_pkg::CH_CR, 1'b1, 1'b0);
      add_item(cse_pkg::CH_ESC, 1'b1, 1'b1);
      add_item(cse_pkg::CH_QUOTE, 1'b1, 1'b0);
      add_item(cse_pkg::CH_COMMA, 1'b1, 1'b0);
      add_item(cse_pkg::CH_BACKSLASH, 1'b1, 1'b0);
      add_item(8'h01, 1'b1, 1'b0);
      add_item(8'h1F, 1'b1, 1'b0);
      add_item(cse_pkg::CH_DEL, 1'b1, 1'b0);
      add_item(8'h80, 1'b1, 1'b0);
      add_item(8'hFF, 1'b1, 1'b0);
      add_item(cse_pkg::CH_SPACE, 1'b1, 1'b0);
      add_item(8'h7E, 1'b1, 1'b1);
      add_item(8'h41, 1'b1, 1'b0);
      add_item(8'h42, 1'b1, 1'b0);
      add_item(8'h43, 1'b1, 1'b0);
      settle();

      // Shrink capacity under an open string: next byte cuts it.
      set_capacity(16'd6);
      add_item(8'h44, 1'b1, 1'b0);
      add_item(8'h45, 1'b1, 1'b0);
      add_item(8'h00, 1'b0, 1'b0);
      add_item(8'h46, 1'b1, 1'b1);
      add_item(8'h78, 1'b1, 1'b1);
      add_item(8'h61, 1'b1, 1'b0);
      add_item(8'h62, 1'b1, 1'b0);
      add_item(8'h63, 1'b1, 1'b1);
      add_item(8'h01, 1'b1, 1'b0);
      add_item(8'h41, 1'b1, 1'b1);
      settle();

      set_capacity(16'd1);
      add_item(8'h41, 1'b1, 1'b1);
      add_item(8'hFF, 1'b0, 1'b1);
      add_item(8'h00, 1'b0, 1'b0);
      add_item(cse_pkg::CH_DEL, 1'b1, 1'b0);
      add_item(8'h20, 1'b1, 1'b1);
      settle();

      caps[0] = 16'hFFFF;
      caps[1] = cse_pkg::CAP_WIDTH'($urandom_range(1, 64));
      caps[2] = 16'd5;
      caps[3] = cse_pkg::CAP_WIDTH'($urandom_range(1, 65535));
      caps[4] = cse_pkg::CAP_RESET;
      caps[5] = cse_pkg::CAP_WIDTH'($urandom_range(1, 64));
      foreach (caps[p]) begin
         set_capacity(caps[p]);
         phase_start = random_items;
         while (random_items - phase_start < 15) begin
            add_string(($urandom_range(0, 4) == 0) ? 40 : 12);
            if ($urandom_range(0, 5) == 0) settle();
         end
         settle();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
